FILE: rtl/pwmpt_pkg.sv
`default_nettype none

package pwmpt_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Duty and period constants
  localparam logic [7:0] DUTY_MAX     = 8'd100;
  localparam logic [7:0] PERIOD_RESET = 8'd100;

  // Command opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result kinds
  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pin_number;
    logic [7:0] duty_percent;
  } cmd_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_pin;
    logic       out_level;
    logic [6:0] out_duty;
    logic       last_of_run;
  } result_t;

  // Write request into the pin table
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       pin;
    logic [6:0]       duty;
  } tbl_wr_t;

endpackage

`default_nettype wire

FILE: rtl/pwmpt_table.sv
`default_nettype none

module pwmpt_table (
  input  wire logic                          clk_i,
  input  wire pwmpt_pkg::tbl_wr_t            wr_i,
  input  wire logic [pwmpt_pkg::IDX_W-1:0]   raddr_i,
  output logic      [7:0]                    rpin_o,
  output logic      [6:0]                    rduty_o
);

  logic [7:0] entry_pin_q  [pwmpt_pkg::TABLE_ENTRIES];
  logic [6:0] entry_duty_q [pwmpt_pkg::TABLE_ENTRIES];

  // Write one entry per cycle; contents stay undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      entry_pin_q[wr_i.addr]  <= wr_i.pin;
      entry_duty_q[wr_i.addr] <= wr_i.duty;
    end
  end

  // Read the entry under the scan pointer
  assign rpin_o  = entry_pin_q[raddr_i];
  assign rduty_o = entry_duty_q[raddr_i];

endmodule

`default_nettype wire

FILE: rtl/pwmpt_seq.sv
`default_nettype none

module pwmpt_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire pwmpt_pkg::cmd_t               cmd_i,
  input  wire logic [7:0]                    period_i,
  output logic                               busy_o,
  output logic                               result_strobe_o,
  output pwmpt_pkg::result_t                 result_o,
  output pwmpt_pkg::tbl_wr_t                 tbl_wr_o,
  output logic [pwmpt_pkg::IDX_W-1:0]        tbl_raddr_o,
  input  wire logic [7:0]                    tbl_rpin_i,
  input  wire logic [6:0]                    tbl_rduty_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TSCAN,
    S_FIND,
    S_SHIFT,
    S_DONE
  } state_e;

  localparam int unsigned CW = pwmpt_pkg::CNT_W;
  localparam int unsigned IW = pwmpt_pkg::IDX_W;

  state_e             state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic [7:0]         pin_q, pin_d;
  logic [6:0]         duty_q, duty_d;
  logic               restart_q, restart_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic [7:0]         tick_q, tick_d;
  logic               pend_vld_q, pend_vld_d;
  pwmpt_pkg::result_t pend_q, pend_d;
  logic               strobe_q, strobe_d;
  pwmpt_pkg::result_t result_q, result_d;

  logic [CW-1:0] idx_next;
  logic [CW-1:0] rd_idx;
  logic          in_range;
  logic          shift_more;
  logic          duty_static;
  logic          table_full;
  logic [6:0]    duty_clamped;
  logic [7:0]    cmp_key;
  logic [7:0]    cmp_ref;
  logic          cmp_eq;

  assign idx_next    = idx_q + CW'(1);
  assign in_range    = idx_q < count_q;
  assign shift_more  = idx_next < count_q;
  assign duty_static = (duty_q == 7'd0) || (duty_q == pwmpt_pkg::DUTY_MAX[6:0]);
  assign table_full  = count_q == CW'(pwmpt_pkg::TABLE_ENTRIES);

  // Clamp requested duty to the full-scale value
  assign duty_clamped = (cmd_i.duty_percent > pwmpt_pkg::DUTY_MAX) ?
                        pwmpt_pkg::DUTY_MAX[6:0] : cmd_i.duty_percent[6:0];

  // Point the read port one entry ahead while compacting the table
  assign rd_idx      = (state_q == S_SHIFT) ? idx_next : idx_q;
  assign tbl_raddr_o = rd_idx[IW-1:0];

  // Shared comparator: pin match while searching, duty match while ticking
  assign cmp_key = (state_q == S_FIND) ? tbl_rpin_i : {1'b0, tbl_rduty_i};
  assign cmp_ref = (state_q == S_FIND) ? pin_q : tick_q;
  assign cmp_eq  = cmp_key == cmp_ref;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pin_d      = pin_q;
    duty_d     = duty_q;
    restart_d  = restart_q;
    idx_d      = idx_q;
    count_d    = count_q;
    tick_d     = tick_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    strobe_d   = 1'b0;
    result_d   = result_q;
    tbl_wr_o   = '0;

    case (state_q)
      // Take a new item
      S_IDLE: begin
        if (start_i) begin
          op_d       = cmd_i.opcode;
          pin_d      = cmd_i.pin_number;
          duty_d     = duty_clamped;
          restart_d  = tick_q >= period_i;
          idx_d      = '0;
          pend_vld_d = 1'b0;
          case (cmd_i.opcode)
            pwmpt_pkg::OP_TICK:  state_d = S_TSCAN;
            pwmpt_pkg::OP_SET:   state_d = S_FIND;
            pwmpt_pkg::OP_QUERY: state_d = S_FIND;
            default:             state_d = S_IDLE;
          endcase
        end
      end

      // Walk the table, hold back one level write so the last can be marked
      S_TSCAN: begin
        if (in_range) begin
          if (restart_q || cmp_eq) begin
            if (pend_vld_q) begin
              strobe_d             = 1'b1;
              result_d             = pend_q;
              result_d.last_of_run = 1'b0;
            end
            pend_d.result_kind = pwmpt_pkg::KIND_LEVEL;
            pend_d.out_pin     = tbl_rpin_i;
            pend_d.out_level   = restart_q;
            pend_d.out_duty    = 7'd0;
            pend_d.last_of_run = 1'b0;
            pend_vld_d         = 1'b1;
          end
          idx_d = idx_next;
        end else begin
          tick_d  = restart_q ? 8'd0 : tick_q + 8'd1;
          state_d = S_DONE;
        end
      end

      // Search for the addressed pin
      S_FIND: begin
        pend_d.result_kind = (op_q == pwmpt_pkg::OP_QUERY) ?
                             pwmpt_pkg::KIND_QUERY : pwmpt_pkg::KIND_LEVEL;
        pend_d.out_pin     = pin_q;
        pend_d.out_level   = 1'b0;
        pend_d.out_duty    = 7'd0;
        pend_d.last_of_run = 1'b0;
        if (in_range) begin
          if (cmp_eq) begin
            if (op_q == pwmpt_pkg::OP_QUERY) begin
              pend_d.out_duty = tbl_rduty_i;
              pend_vld_d      = 1'b1;
              state_d         = S_DONE;
            end else if (duty_static) begin
              pend_d.out_level = duty_q == pwmpt_pkg::DUTY_MAX[6:0];
              pend_vld_d       = 1'b1;
              state_d          = S_SHIFT;
            end else begin
              tbl_wr_o.we   = 1'b1;
              tbl_wr_o.addr = idx_q[IW-1:0];
              tbl_wr_o.pin  = pin_q;
              tbl_wr_o.duty = duty_q;
              state_d       = S_DONE;
            end
          end else begin
            idx_d = idx_next;
          end
        end else begin
          if (op_q == pwmpt_pkg::OP_QUERY) begin
            pend_vld_d = 1'b1;
          end else if (!duty_static && !table_full) begin
            tbl_wr_o.we   = 1'b1;
            tbl_wr_o.addr = count_q[IW-1:0];
            tbl_wr_o.pin  = pin_q;
            tbl_wr_o.duty = duty_q;
            count_d       = count_q + CW'(1);
          end
          state_d = S_DONE;
        end
      end

      // Move later entries down over the removed one
      S_SHIFT: begin
        if (shift_more) begin
          tbl_wr_o.we   = 1'b1;
          tbl_wr_o.addr = idx_q[IW-1:0];
          tbl_wr_o.pin  = tbl_rpin_i;
          tbl_wr_o.duty = tbl_rduty_i;
          idx_d         = idx_next;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      // Flush the held result as the last of the run
      S_DONE: begin
        if (pend_vld_q) begin
          strobe_d             = 1'b1;
          result_d             = pend_q;
          result_d.last_of_run = 1'b1;
        end
        pend_vld_d = 1'b0;
        state_d    = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= '0;
      pin_q      <= '0;
      duty_q     <= '0;
      restart_q  <= 1'b0;
      idx_q      <= '0;
      count_q    <= '0;
      tick_q     <= '0;
      pend_vld_q <= 1'b0;
      pend_q     <= '0;
      strobe_q   <= 1'b0;
      result_q   <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      pin_q      <= pin_d;
      duty_q     <= duty_d;
      restart_q  <= restart_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
      tick_q     <= tick_d;
      pend_vld_q <= pend_vld_d;
      pend_q     <= pend_d;
      strobe_q   <= strobe_d;
      result_q   <= result_d;
    end
  end

  assign busy_o          = state_q != S_IDLE;
  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

`default_nettype wire

FILE: rtl/multi_pin_pwm_with_pin_table_core.sv
// Results: the sequencer walks the table one entry per cycle; the last result of a run
// carries last_of_run and is strobed as busy drops.
// Busy: busy stays high while a tick, set or query is processed, and a new item is taken
// only while busy is low, as the single table read port serves one item at a time.
// An unused opcode leaves busy low.
// Reset: rst_ni clears the table count, tick counter and sequencer; period reloads 100.
// Results are strobed for one cycle each; the receiver cannot stall them.
`default_nettype none

module multi_pin_pwm_with_pin_table_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire pwmpt_pkg::cmd_t    cmd_i,
  output logic                    result_strobe_o,
  output pwmpt_pkg::result_t      result_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i
);

  logic [7:0]                  period_q;
  pwmpt_pkg::tbl_wr_t          tbl_wr;
  logic [pwmpt_pkg::IDX_W-1:0] tbl_raddr;
  logic [7:0]                  tbl_rpin;
  logic [6:0]                  tbl_rduty;

  // Hold the period register; writes arrive only while idle
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= pwmpt_pkg::PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= cfg_data_i;
    end
  end

  pwmpt_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .cmd_i           (cmd_i),
    .period_i        (period_q),
    .busy_o          (busy),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .tbl_wr_o        (tbl_wr),
    .tbl_raddr_o     (tbl_raddr),
    .tbl_rpin_i      (tbl_rpin),
    .tbl_rduty_i     (tbl_rduty)
  );

  pwmpt_table u_table (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .raddr_i (tbl_raddr),
    .rpin_o  (tbl_rpin),
    .rduty_o (tbl_rduty)
  );

  // No result in the cycle right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_strobe_o)
    else $error("result strobed directly after item accept");

  // The last result of a run coincides with the return to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last_of_run) |-> !busy)
    else $error("last result while still busy");

  // Intermediate results only occur mid-scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.last_of_run) |-> busy)
    else $error("unterminated run of results");

  // A queried duty never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && (result_o.result_kind == pwmpt_pkg::KIND_QUERY))
      |-> (result_o.out_duty <= pwmpt_pkg::DUTY_MAX[6:0]))
    else $error("queried duty out of range");

endmodule

`default_nettype wire
